// ----- rtl/ookt_pkg.sv -----
// Package with the shared types, codes, constants and pulse timing table of the OOK transmitter.
`default_nettype none
package ookt_pkg;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_BIT_FORMAT   = 2'd0,
    CFG_UNIT_TICKS   = 2'd1,
    CFG_REPEAT_COUNT = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic        BitFormatRst   = 1'b0;
  localparam logic [15:0] UnitTicksRst   = 16'd120;
  localparam logic [7:0]  RepeatCountRst = 8'd8;

  localparam logic [5:0] FrameLenShort = 6'd24;
  localparam logic [5:0] SyncLowUnits  = 6'd47;

  typedef struct packed {
    logic        bit_format;
    logic [15:0] unit_ticks;
    logic [7:0]  repeat_count;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic finished;
  } res_t;

  // Length in units of one span. Even phases are high spans, odd phases low spans.
  function automatic logic [5:0] phase_units(input logic fmt, input logic sync,
                                             input logic bit_val, input logic [2:0] ph);
    logic [5:0] units;
    if (sync) begin
      units = ph[0] ? SyncLowUnits : 6'd1;
    end else if (fmt) begin
      if (bit_val) units = ph[0] ? 6'd4 : 6'd1;
      else         units = ph[0] ? 6'd1 : 6'd4;
    end else if (!ph[0]) begin
      units = 6'd1;
    end else if (bit_val) begin
      units = (ph == 3'd1) ? 6'd2 : 6'd10;
    end else begin
      units = (ph == 3'd1) ? 6'd10 : 6'd2;
    end
    return units;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ook_remote_code_transmitter_core.sv -----
// The result of a transaction is registered and appears in the cycle after it is accepted.
// Throughput: one input transaction per clock; the input is ready whenever the
// result register is empty or its content is taken in the same cycle.
// Reset: asynchronous, active low; idles with the carrier off and the registers
// at their defaults (format 0, 120 ticks per unit, 8 repeats).
`default_nettype none
module ook_remote_code_transmitter_core
  import ookt_pkg::*;
#(
  parameter int unsigned CODE_BITS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [31:0]         s_axis_tdata,   // code_word
  input  wire logic                s_axis_tuser,   // operation
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [7:0]          m_axis_tdata,   // line_level, busy_res, zero padding
  output      logic                m_axis_tlast,   // finished
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic out_valid_q, out_valid_d;
  logic in_accept;

  ookt_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  ookt_seq #(
    .CODE_BITS (CODE_BITS)
  ) u_seq (
    .clk_i,
    .rst_ni,
    .step_i (in_accept),
    .op_i   (s_axis_tuser),
    .code_i (s_axis_tdata),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, res_q.busy_res, res_q.line_level};
  assign m_axis_tlast  = res_q.finished;

endmodule
`default_nettype wire

// ----- rtl/ookt_cfg.sv -----
// Configuration register bank of the OOK transmitter.
`default_nettype none
module ookt_cfg
  import ookt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BIT_FORMAT:   cfg_d.bit_format   = cfg_data_i[0];
        CFG_UNIT_TICKS:   cfg_d.unit_ticks   = cfg_data_i[15:0];
        CFG_REPEAT_COUNT: cfg_d.repeat_count = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_format   <= BitFormatRst;
      cfg_q.unit_ticks   <= UnitTicksRst;
      cfg_q.repeat_count <= RepeatCountRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ----- rtl/ookt_seq.sv -----
// Pulse sequencer: transmission state and its single-pass update for one transaction.
`default_nettype none
module ookt_seq
  import ookt_pkg::*;
#(
  parameter int unsigned CODE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic        op_i,
  input  wire logic [31:0] code_i,
  input  wire cfg_t        cfg_i,
  output res_t             res_o
);

  localparam logic [5:0] FrameLenLong = 6'(CODE_BITS);

  logic [31:0] code_q, code_d;
  logic [5:0]  bp_q, bp_d;
  logic [7:0]  rd_q, rd_d;
  logic [2:0]  ph_q, ph_d;
  logic [5:0]  ul_q, ul_d;
  logic [15:0] pre_q, pre_d;
  logic        send_q, send_d;
  logic        pin_q, pin_d;

  logic [5:0]  frame_len;
  logic        sync_q;
  logic [3:0]  group_phases;
  logic        unit_wrap;
  logic [5:0]  ul_dec;
  logic [7:0]  reps;
  logic        fin;
  logic        enter;
  logic [2:0]  ph_n;
  logic        sync_n;
  logic [4:0]  bit_idx;
  logic [5:0]  idx_full;

  assign frame_len    = cfg_i.bit_format ? FrameLenShort : FrameLenLong;
  assign sync_q       = (bp_q >= frame_len);
  assign group_phases = (sync_q || cfg_i.bit_format) ? 4'd2 : 4'd4;
  assign unit_wrap    = ({1'b0, pre_q} + 17'd1) >= {1'b0, cfg_i.unit_ticks};
  assign ul_dec       = (ul_q != 6'd0) ? ul_q - 6'd1 : 6'd0;
  assign reps         = (cfg_i.repeat_count != 8'd0) ? cfg_i.repeat_count : 8'd1;

  always_comb begin
    code_d   = code_q;
    bp_d     = bp_q;
    rd_d     = rd_q;
    ph_d     = ph_q;
    ul_d     = ul_q;
    pre_d    = pre_q;
    send_d   = send_q;
    pin_d    = pin_q;
    fin      = 1'b0;
    enter    = 1'b0;
    ph_n     = 3'd0;
    sync_n   = 1'b0;
    idx_full = 6'd0;
    bit_idx  = 5'd0;

    if (step_i) begin
      if (op_e'(op_i) == OP_START) begin
        if (!send_q) begin
          code_d = code_i;
          bp_d   = 6'd0;
          rd_d   = 8'd0;
          pre_d  = 16'd0;
          send_d = 1'b1;
          enter  = 1'b1;
        end
      end else if (send_q) begin
        if (unit_wrap) begin
          pre_d = 16'd0;
          ul_d  = ul_dec;
          if (ul_dec == 6'd0) begin
            if (({1'b0, ph_q} + 4'd1) < group_phases) begin
              enter = 1'b1;
              ph_n  = ph_q + 3'd1;
            end else if (sync_q) begin
              // End of a frame: either start the next repeat or stop.
              bp_d = 6'd0;
              rd_d = rd_q + 8'd1;
              if (rd_d >= reps) begin
                send_d = 1'b0;
                pin_d  = 1'b0;
                ph_d   = 3'd0;
                ul_d   = 6'd0;
                fin    = 1'b1;
              end else begin
                enter = 1'b1;
              end
            end else begin
              bp_d  = bp_q + 6'd1;
              enter = 1'b1;
            end
          end
        end else begin
          pre_d = pre_q + 16'd1;
        end
      end
    end

    // Entering a span looks at the updated bit position and code.
    if (enter) begin
      sync_n   = (bp_d >= frame_len);
      idx_full = frame_len - 6'd1 - bp_d;
      bit_idx  = idx_full[4:0];
      ph_d     = ph_n;
      ul_d     = phase_units(cfg_i.bit_format, sync_n, code_d[bit_idx], ph_n);
      pin_d    = ~ph_n[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
      bp_q   <= '0;
      rd_q   <= '0;
      ph_q   <= '0;
      ul_q   <= '0;
      pre_q  <= '0;
      send_q <= 1'b0;
      pin_q  <= 1'b0;
    end else begin
      code_q <= code_d;
      bp_q   <= bp_d;
      rd_q   <= rd_d;
      ph_q   <= ph_d;
      ul_q   <= ul_d;
      pre_q  <= pre_d;
      send_q <= send_d;
      pin_q  <= pin_d;
    end
  end

  assign res_o.line_level = pin_d;
  assign res_o.busy_res   = send_d;
  assign res_o.finished   = fin;

endmodule
`default_nettype wire

// ----- tb/sv/ook_remote_code_transmitter_core_tb.sv -----
// Self-checking testbench for the OOK remote-code transmitter core.
`timescale 1ns / 100ps

module ook_remote_code_transmitter_core_tb;
  import ookt_pkg::*;

  localparam int unsigned CodeBits  = 32;
  localparam int          IdleLimit = 1000;
  localparam int          ItemGoal  = 1000;
  localparam res_t        ResIdle      = 3'b000;  // carrier off, not busy
  localparam res_t        ResFirstHigh = 3'b110;  // carrier on, busy, not finished

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata = '0;
  logic                s_axis_tuser = OP_TICK;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  ook_remote_code_transmitter_core #(
    .CODE_BITS(CodeBits)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the transmitter: registers and sequencing state.
  logic        fmt_q;
  logic [15:0] unit_q;
  logic [7:0]  reps_q;
  logic [31:0] code_q;
  logic [5:0]  bitpos_q;
  logic [7:0]  done_q;
  logic [2:0]  phase_q;
  logic [5:0]  units_q;
  logic [15:0] presc_q;
  logic        busy_q;
  logic        pin_q;

  res_t level_q[$];
  int   mismatches = 0;
  int   useful_items = 0;
  int   burst_left = 1;
  int   gap_left = 0;

  function automatic int frame_bits();
    return fmt_q ? int'(FrameLenShort) : CodeBits;
  endfunction

  function automatic bit in_sync_span();
    return int'(bitpos_q) >= frame_bits();
  endfunction

  function automatic logic [5:0] span_units(logic [2:0] ph);
    int   idx;
    logic bit_val;
    idx = (frame_bits() - 1 - int'(bitpos_q)) & 31;
    bit_val = code_q[idx];
    if (in_sync_span()) return ph[0] ? 6'd47 : 6'd1;
    if (fmt_q) begin
      if (bit_val) return ph[0] ? 6'd4 : 6'd1;
      return ph[0] ? 6'd1 : 6'd4;
    end
    if (!ph[0]) return 6'd1;
    if (bit_val) return (ph == 3'd1) ? 6'd2 : 6'd10;
    return (ph == 3'd1) ? 6'd10 : 6'd2;
  endfunction

  function automatic void start_span(logic [2:0] ph);
    phase_q = ph;
    units_q = span_units(ph);
    pin_q   = !ph[0];
  endfunction

  // Moves to the next span; returns 1 when the last frame has just ended.
  function automatic bit next_span();
    int groups;
    groups = (in_sync_span() || fmt_q) ? 2 : 4;
    if (int'(phase_q) + 1 < groups) begin
      start_span(phase_q + 3'd1);
      return 1'b0;
    end
    if (in_sync_span()) begin
      bitpos_q = '0;
      done_q   = done_q + 8'd1;
      if (done_q >= ((reps_q == 8'd0) ? 8'd1 : reps_q)) begin
        busy_q  = 1'b0;
        pin_q   = 1'b0;
        phase_q = '0;
        units_q = '0;
        return 1'b1;
      end
    end else begin
      bitpos_q = bitpos_q + 6'd1;
    end
    start_span(3'd0);
    return 1'b0;
  endfunction

  function automatic res_t line_step(op_e op, logic [31:0] code);
    res_t r;
    bit   fin;
    fin = 1'b0;
    if (op == OP_START) begin
      if (!busy_q) begin
        code_q   = code;
        bitpos_q = '0;
        done_q   = '0;
        presc_q  = '0;
        busy_q   = 1'b1;
        start_span(3'd0);
      end
    end else if (busy_q) begin
      if (({1'b0, presc_q} + 17'd1) >= {1'b0, unit_q}) begin
        presc_q = '0;
        if (units_q != 6'd0) units_q = units_q - 6'd1;
        if (units_q == 6'd0) fin = next_span();
      end else begin
        presc_q = presc_q + 16'd1;
      end
    end
    r.line_level = pin_q;
    r.busy_res   = busy_q;
    r.finished   = fin;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(op_e op, logic [31:0] code, bit typed, res_t want);
    res_t got;
    cfg_we_i <= 1'b0;
    while (gap_left > 0) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
      gap_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= code;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if ((op == OP_TICK) == busy_q) useful_items++;
    got = line_step(op, code);
    level_q.push_back(typed ? want : got);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 60);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    @(negedge clk_i);
  endtask

  // Holds the sender off until every expected transaction has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    cfg_we_i      <= 1'b0;
    while (level_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_BIT_FORMAT:   fmt_q  = val[0];
      CFG_UNIT_TICKS:   unit_q = val;
      CFG_REPEAT_COUNT: reps_q = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic report(string what, res_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected line %0b busy %0b last %0b, got tdata %h last %0b",
               $realtime, what, want.line_level, want.busy_res, want.finished,
               m_axis_tdata, m_axis_tlast);
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (level_q.size() == 0) begin
        report("unexpected transaction", ResIdle);
      end else begin
        want = level_q.pop_front();
        if (m_axis_tdata !== {6'b0, want.busy_res, want.line_level} ||
            m_axis_tlast !== want.finished)
          report("output mismatch", want);
      end
    end
  end

  // The receiver stalls on a periodic pattern whose shape changes now and then.
  int rx_cyc = 0;
  int rx_period = 1;
  int rx_stall = 0;
  always @(negedge clk_i) begin
    if (rx_cyc % 150 == 0) begin
      rx_period = $urandom_range(1, 12);
      rx_stall  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, rx_period - 1);
    end
    m_axis_tready <= (rx_cyc % rx_period) >= rx_stall;
    rx_cyc++;
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  typedef struct {
    bit          is_cfg;
    cfg_idx_e    reg_idx;
    logic [15:0] reg_val;
    op_e         op;
    logic [31:0] code;
    bit          typed;
    res_t        want;
  } stim_row_t;

  stim_row_t plan_q[$];

  function automatic void cfg_row(cfg_idx_e idx, logic [15:0] val);
    stim_row_t r;
    r = '{1'b1, idx, val, OP_TICK, 32'h0, 1'b0, ResIdle};
    plan_q.push_back(r);
  endfunction

  function automatic void item_row(op_e op, logic [31:0] code, bit typed, res_t want);
    stim_row_t r;
    r = '{1'b0, CFG_BIT_FORMAT, 16'h0, op, code, typed, want};
    plan_q.push_back(r);
  endfunction

  initial begin
    bit          prev_cfg;
    int          phase_len;
    op_e         op;
    logic [31:0] code;
    logic [15:0] val;

    fmt_q    = BitFormatRst;
    unit_q   = UnitTicksRst;
    reps_q   = RepeatCountRst;
    code_q   = '0;
    bitpos_q = '0;
    done_q   = '0;
    phase_q  = '0;
    units_q  = '0;
    presc_q  = '0;
    busy_q   = 1'b0;
    pin_q    = 1'b0;

    // Idle tick, start, start while busy, then a format change mid-frame and
    // the zero and maximum register settings.
    item_row(OP_TICK, 32'hFFFF_FFFF, 1'b1, ResIdle);
    cfg_row(CFG_UNIT_TICKS, 16'd1);
    cfg_row(CFG_REPEAT_COUNT, 16'd1);
    item_row(OP_START, 32'hFFFF_FFFF, 1'b1, ResFirstHigh);
    item_row(OP_START, 32'h0000_0000, 1'b1, ResFirstHigh);
    repeat (3) item_row(OP_TICK, 32'h0, 1'b0, ResIdle);
    cfg_row(CFG_BIT_FORMAT, 16'd1);
    repeat (3) item_row(OP_TICK, 32'h0, 1'b0, ResIdle);
    cfg_row(CFG_UNIT_TICKS, 16'd0);
    repeat (3) item_row(OP_TICK, 32'h0, 1'b0, ResIdle);
    cfg_row(CFG_REPEAT_COUNT, 16'd0);
    repeat (2) item_row(OP_TICK, 32'h0, 1'b0, ResIdle);
    cfg_row(CFG_UNIT_TICKS, 16'hFFFF);
    cfg_row(CFG_REPEAT_COUNT, 16'd255);
    item_row(OP_TICK, 32'h0, 1'b0, ResIdle);
    item_row(OP_START, 32'h8000_0001, 1'b0, ResIdle);
    item_row(OP_TICK, 32'h0, 1'b0, ResIdle);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    prev_cfg = 1'b0;
    foreach (plan_q[i]) begin
      if (plan_q[i].is_cfg) begin
        if (!prev_cfg) drain();
        cfg_write(plan_q[i].reg_idx, plan_q[i].reg_val);
      end else begin
        send_item(plan_q[i].op, plan_q[i].code, plan_q[i].typed, plan_q[i].want);
      end
      prev_cfg = plan_q[i].is_cfg;
    end

    // Random phases: mostly ticks at short unit lengths so that whole frames
    // complete, with a fresh register setting between phases.
    useful_items = 0;
    while (useful_items < ItemGoal) begin
      drain();
      if (plan_q.size() != 0 || $urandom_range(0, 2) != 0)
        cfg_write(CFG_BIT_FORMAT, 16'($urandom_range(0, 1)));
      if (plan_q.size() != 0 || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 11))
          0:       val = 16'd0;
          1:       val = 16'hFFFF;
          2, 3:    val = 16'($urandom_range(2, 4));
          4:       val = 16'($urandom_range(5, 20));
          default: val = 16'd1;
        endcase
        cfg_write(CFG_UNIT_TICKS, val);
      end
      if (plan_q.size() != 0 || $urandom_range(0, 2) != 0) begin
        val = ($urandom_range(0, 11) == 0) ? 16'd255 : 16'($urandom_range(0, 3));
        cfg_write(CFG_REPEAT_COUNT, val);
      end
      plan_q.delete();
      phase_len = $urandom_range(100, 300);
      repeat (phase_len) begin
        if (busy_q) op = ($urandom_range(0, 24) == 0) ? OP_START : OP_TICK;
        else        op = ($urandom_range(0, 1) == 0) ? OP_START : OP_TICK;
        case ($urandom_range(0, 7))
          0:       code = 32'h0000_0000;
          1:       code = 32'hFFFF_FFFF;
          default: code = $urandom;
        endcase
        send_item(op, code, 1'b0, ResIdle);
      end
    end

    drain();
    repeat (3) @(posedge clk_i);
    if (mismatches == 0 && level_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
